// ----- rtl/assert_macros.svh -----
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define RSFE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RSFE_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define RSFE_ASSERT(lbl, clk, rst_n, prop, msg)
`define RSFE_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

// ----- rtl/rsfe_pkg.sv -----
`default_nettype none

package rsfe_pkg;

    localparam int MAX_RECORDS = 16;
    localparam int ID_W        = 8;
    localparam int ENERGY_W    = 64;
    localparam int IN_TDATA_W  = 264;
    localparam int OUT_TDATA_W = 328;

    // one stored record, id in the lowest bits
    typedef struct packed {
        logic signed [ENERGY_W-1:0] freq;
        logic signed [ENERGY_W-1:0] key;
        logic signed [ENERGY_W-1:0] point;
        logic signed [ENERGY_W-1:0] free;
        logic signed [ENERGY_W-1:0] opt;
        logic        [ID_W-1:0]     id;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

    typedef enum logic [2:0] {
        S_LOAD,
        S_SORT_RD0,
        S_SORT_FIRST,
        S_SORT_STEP,
        S_SORT_END,
        S_OUT_RD,
        S_OUT_LD,
        S_OUT_WAIT
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/rsfe_ram.sv -----
`default_nettype none

module rsfe_ram #(
    parameter int WIDTH = rsfe_pkg::REC_W,
    parameter int DEPTH = rsfe_pkg::MAX_RECORDS
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/rsfe_key.sv -----
`default_nettype none

// corrected free energy: point + free - opt, saturated to 64 bits
module rsfe_key (
    input  wire logic signed [rsfe_pkg::ENERGY_W-1:0] i_point,
    input  wire logic signed [rsfe_pkg::ENERGY_W-1:0] i_free,
    input  wire logic signed [rsfe_pkg::ENERGY_W-1:0] i_opt,
    output logic signed      [rsfe_pkg::ENERGY_W-1:0] o_key
);

    localparam int EW = rsfe_pkg::ENERGY_W;

    logic [EW+1:0] w_sum;

    assign w_sum = {{2{i_point[EW-1]}}, i_point} + {{2{i_free[EW-1]}}, i_free}
                 - {{2{i_opt[EW-1]}}, i_opt};

    always_comb begin
        if (w_sum[EW+1:EW-1] == 3'b000 || w_sum[EW+1:EW-1] == 3'b111) begin
            o_key = w_sum[EW-1:0];
        end else if (w_sum[EW+1]) begin
            o_key = {1'b1, {(EW-1){1'b0}}};
        end else begin
            o_key = {1'b0, {(EW-1){1'b1}}};
        end
    end

endmodule

`default_nettype wire

// ----- rtl/record_sort_by_free_energy.sv -----
// Load: one cycle per record, o_s_tready high only while gathering a set.
// Sort: bubble passes over the record RAM, each pass reading and writing back every record;
// passes repeat until one moves nothing (at most n passes for n records), one RAM read and write a cycle.
// Output: each record is read from the RAM into the output register, the next only after each beat is taken.
// Reset (synchronous, active low) empties the set and clears the drop flag.
`default_nettype none

module record_sort_by_free_energy #(
    parameter int MAX_RECORDS = rsfe_pkg::MAX_RECORDS
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    // isomer_id, opt_energy, opt_free_energy, point_energy, low_frequency
    input  wire logic [rsfe_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    input  wire logic                               i_s_tlast,
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready,
    // out_id, out_opt_energy, out_opt_free, out_point_energy,
    // out_corrected_free, out_frequency
    output logic      [rsfe_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    output logic                                    o_m_tlast,
    // out_dropped
    output logic                                    o_m_tuser
);

`include "assert_macros.svh"

    localparam int CW = $clog2(MAX_RECORDS + 1);
    localparam int AW = $clog2(MAX_RECORDS);
    localparam int EW = rsfe_pkg::ENERGY_W;
    localparam int IW = rsfe_pkg::ID_W;
    localparam logic [CW-1:0] MAXC = CW'(MAX_RECORDS);

    rsfe_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic             r_drop, n_drop;
    logic [CW-1:0]    r_idx, n_idx;
    logic [CW-1:0]    r_k, n_k;
    logic             r_moved, n_moved;
    rsfe_pkg::t_rec   r_carry, n_carry;
    rsfe_pkg::t_rec   r_out, n_out;
    logic             r_out_valid, n_out_valid;
    logic             r_out_last, n_out_last;
    logic             r_out_drop, n_out_drop;

    rsfe_pkg::t_rec   w_in_rec;
    rsfe_pkg::t_rec   w_rd;
    rsfe_pkg::t_rec   w_wr_data;
    logic [rsfe_pkg::REC_W-1:0] w_rd_raw;
    logic signed [EW-1:0] w_key;
    logic             w_wr_en, w_rd_en;
    logic [AW-1:0]    w_wr_addr, w_rd_addr;
    logic             w_full;
    logic [CW-1:0]    w_cnt_after;
    logic [CW-1:0]    w_idx_m2;
    logic [CW-1:0]    w_last_idx;
    logic             w_swap;

    rsfe_key u_key (
        .i_point (i_s_tdata[199:136]),
        .i_free  (i_s_tdata[135:72]),
        .i_opt   (i_s_tdata[71:8]),
        .o_key   (w_key)
    );

    assign w_in_rec.id    = i_s_tdata[IW-1:0];
    assign w_in_rec.opt   = i_s_tdata[71:8];
    assign w_in_rec.free  = i_s_tdata[135:72];
    assign w_in_rec.point = i_s_tdata[199:136];
    assign w_in_rec.key   = w_key;
    assign w_in_rec.freq  = i_s_tdata[263:200];

    rsfe_ram #(
        .WIDTH (rsfe_pkg::REC_W),
        .DEPTH (MAX_RECORDS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_raw)
    );

    assign w_rd        = w_rd_raw;
    assign w_full      = (r_count == MAXC);
    assign w_cnt_after = w_full ? r_count : CW'(r_count + CW'(1));
    assign w_idx_m2    = CW'(r_idx - CW'(2));
    assign w_last_idx  = CW'(r_count - CW'(1));
    // strict compare keeps equal keys in arrival order
    assign w_swap      = (r_carry.key > w_rd.key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rsfe_pkg::S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
            r_moved     <= 1'b0;
            r_idx       <= '0;
            r_k         <= '0;
        end else begin
            r_count     <= n_count;
            r_drop      <= n_drop;
            r_out_valid <= n_out_valid;
            r_moved     <= n_moved;
            r_idx       <= n_idx;
            r_k         <= n_k;
        end
        r_carry    <= n_carry;
        r_out      <= n_out;
        r_out_last <= n_out_last;
        r_out_drop <= n_out_drop;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_drop      = r_drop;
        n_idx       = r_idx;
        n_k         = r_k;
        n_moved     = r_moved;
        n_carry     = r_carry;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        n_out_last  = r_out_last;
        n_out_drop  = r_out_drop;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_count[AW-1:0];
        w_wr_data   = w_in_rec;
        w_rd_en     = 1'b0;
        w_rd_addr   = '0;
        o_s_tready  = 1'b0;

        case (r_state)
            rsfe_pkg::S_LOAD: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    if (w_full) begin
                        n_drop = 1'b1;
                    end else begin
                        w_wr_en = 1'b1;
                        n_count = w_cnt_after;
                    end
                    if (i_s_tlast) begin
                        n_k     = '0;
                        n_state = (w_cnt_after > CW'(1)) ? rsfe_pkg::S_SORT_RD0
                                                         : rsfe_pkg::S_OUT_RD;
                    end
                end
            end
            rsfe_pkg::S_SORT_RD0: begin
                w_rd_en   = 1'b1;
                w_rd_addr = '0;
                n_idx     = CW'(1);
                n_moved   = 1'b0;
                n_state   = rsfe_pkg::S_SORT_FIRST;
            end
            rsfe_pkg::S_SORT_FIRST: begin
                n_carry   = w_rd;
                w_rd_en   = 1'b1;
                w_rd_addr = r_idx[AW-1:0];
                n_idx     = CW'(r_idx + CW'(1));
                n_state   = rsfe_pkg::S_SORT_STEP;
            end
            rsfe_pkg::S_SORT_STEP: begin
                // carry holds the largest key so far; drop the smaller one behind it
                w_wr_en   = 1'b1;
                w_wr_addr = w_idx_m2[AW-1:0];
                if (w_swap) begin
                    w_wr_data = w_rd;
                    n_moved   = 1'b1;
                end else begin
                    w_wr_data = r_carry;
                    n_carry   = w_rd;
                end
                if (r_idx == r_count) begin
                    n_state = rsfe_pkg::S_SORT_END;
                end else begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_idx[AW-1:0];
                    n_idx     = CW'(r_idx + CW'(1));
                end
            end
            rsfe_pkg::S_SORT_END: begin
                w_wr_en   = 1'b1;
                w_wr_addr = w_last_idx[AW-1:0];
                w_wr_data = r_carry;
                if (r_moved) begin
                    n_state = rsfe_pkg::S_SORT_RD0;
                end else begin
                    n_k     = '0;
                    n_state = rsfe_pkg::S_OUT_RD;
                end
            end
            rsfe_pkg::S_OUT_RD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = r_k[AW-1:0];
                n_state   = rsfe_pkg::S_OUT_LD;
            end
            rsfe_pkg::S_OUT_LD: begin
                n_out       = w_rd;
                n_out_valid = 1'b1;
                n_out_last  = (CW'(r_k + CW'(1)) == r_count);
                n_out_drop  = r_drop;
                n_k         = CW'(r_k + CW'(1));
                n_state     = rsfe_pkg::S_OUT_WAIT;
            end
            rsfe_pkg::S_OUT_WAIT: begin
                if (i_m_tready) begin
                    n_out_valid = 1'b0;
                    if (r_out_last) begin
                        n_count = '0;
                        n_drop  = 1'b0;
                        n_state = rsfe_pkg::S_LOAD;
                    end else begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = r_k[AW-1:0];
                        n_state   = rsfe_pkg::S_OUT_LD;
                    end
                end
            end
            default: begin
                n_state = rsfe_pkg::S_LOAD;
            end
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_drop;
    assign o_m_tdata  = {r_out.freq, r_out.key, r_out.point, r_out.free, r_out.opt, r_out.id};

    `RSFE_NEVER(a_load_while_out, i_clk, i_rst_n, o_s_tready && r_out_valid, "load during output")
    `RSFE_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= MAXC, "record count past capacity")
    `RSFE_ASSERT(a_step_idx, i_clk, i_rst_n, (r_state == rsfe_pkg::S_SORT_STEP) |-> (r_idx >= CW'(2) && r_idx <= r_count), "sort index out of range")
    `RSFE_ASSERT(a_run_end, i_clk, i_rst_n, (o_m_tvalid && i_m_tready && o_m_tlast) |=> (r_count == '0 && !r_drop && o_s_tready), "set not cleared after last beat")

endmodule

`default_nettype wire

// ----- tb/rsfe_sort_checker.sv -----
`timescale 1ns / 100ps

module rsfe_sort_checker
    import rsfe_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    // isomer_id, opt_energy, opt_free_energy, point_energy, low_frequency
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                   i_s_tlast,
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    // out_id, out_opt_energy, out_opt_free, out_point_energy,
    // out_corrected_free, out_frequency
    input  logic [OUT_TDATA_W-1:0] i_m_tdata,
    input  logic                   i_m_tlast,
    // out_dropped
    input  logic                   i_m_tuser,
    output int                     o_failures,
    output int                     o_pending
);

    typedef struct packed {
        t_rec rec;
        logic last;
        logic dropped;
    } t_sorted_beat;

    t_rec         held_recs [MAX_RECORDS];
    int           held_count;
    logic         drop_seen;
    t_sorted_beat sorted_q [$];
    int           fail_count = 0;
    int           beats_seen = 0;

    // point + free - opt, exact in 66 bits, then clamp to the signed 64-bit range
    function automatic logic [63:0] corrected_free(logic [63:0] opt, logic [63:0] free,
                                                   logic [63:0] point);
        logic [65:0] sum;
        sum = {{2{point[63]}}, point} + {{2{free[63]}}, free} - {{2{opt[63]}}, opt};
        if (sum[65:63] == 3'b000 || sum[65:63] == 3'b111)
            return sum[63:0];
        else if (!sum[65])
            return 64'h7FFF_FFFF_FFFF_FFFF;
        else
            return 64'h8000_0000_0000_0000;
    endfunction

    function automatic void take_record(logic [IN_TDATA_W-1:0] d, logic last);
        t_rec         r;
        t_rec         order [MAX_RECORDS];
        t_rec         tmp;
        bit           moved;
        t_sorted_beat b;
        if (held_count < MAX_RECORDS) begin
            r.id    = d[7:0];
            r.opt   = d[71:8];
            r.free  = d[135:72];
            r.point = d[199:136];
            r.freq  = d[263:200];
            r.key   = corrected_free(r.opt, r.free, r.point);
            held_recs[held_count] = r;
            held_count++;
        end else begin
            drop_seen = 1'b1;
        end
        if (!last)
            return;
        // strict compare keeps equal keys in arrival order
        order = held_recs;
        moved = 1'b1;
        while (moved) begin
            moved = 1'b0;
            for (int i = 0; i + 1 < held_count; i++) begin
                if ($signed(order[i].key) > $signed(order[i+1].key)) begin
                    tmp        = order[i];
                    order[i]   = order[i+1];
                    order[i+1] = tmp;
                    moved      = 1'b1;
                end
            end
        end
        for (int k = 0; k < held_count; k++) begin
            b.rec     = order[k];
            b.last    = (k == held_count - 1);
            b.dropped = drop_seen;
            sorted_q.push_back(b);
        end
        held_count = 0;
        drop_seen  = 1'b0;
    endfunction

    function automatic void show_beat(string tag, t_sorted_beat b);
        $display("  %s id %02h opt %h free %h point %h key %h freq %h last %b dropped %b",
                 tag, b.rec.id, b.rec.opt, b.rec.free, b.rec.point, b.rec.key,
                 b.rec.freq, b.last, b.dropped);
    endfunction

    function automatic void check_beat();
        t_sorted_beat got;
        t_sorted_beat want;
        got.rec     = i_m_tdata;
        got.last    = i_m_tlast;
        got.dropped = i_m_tuser;
        if (sorted_q.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) begin
                $display("beat %0d: no result expected", beats_seen);
                show_beat("actual  ", got);
            end
        end else begin
            want = sorted_q.pop_front();
            if (got.rec.id !== want.rec.id || got.rec.opt !== want.rec.opt ||
                got.rec.free !== want.rec.free || got.rec.point !== want.rec.point ||
                got.rec.key !== want.rec.key || got.rec.freq !== want.rec.freq ||
                got.last !== want.last || got.dropped !== want.dropped) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("beat %0d: mismatch", beats_seen);
                    show_beat("expected", want);
                    show_beat("actual  ", got);
                end
            end
        end
        beats_seen++;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_count = 0;
            drop_seen  = 1'b0;
            sorted_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready)
                take_record(i_s_tdata, i_s_tlast);
            if (i_m_tvalid && i_m_tready)
                check_beat();
        end
        o_failures <= fail_count;
        o_pending  <= sorted_q.size();
    end

endmodule

// ----- tb/tb_record_sort_by_free_energy.sv -----
`timescale 1ns / 100ps

module tb_record_sort_by_free_energy;
    import rsfe_pkg::*;

    localparam int          TIMEOUT_NS   = 2_000_000;
    localparam int          DIRECTED_N   = 21;
    localparam int          RANDOM_N     = 80;
    localparam logic [63:0] E_MAX        = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] E_MIN        = 64'h8000_0000_0000_0000;

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    // isomer_id, opt_energy, opt_free_energy, point_energy, low_frequency
    logic [IN_TDATA_W-1:0]  i_s_tdata  = '0;
    logic                   i_s_tlast  = 1'b0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    // out_id, out_opt_energy, out_opt_free, out_point_energy,
    // out_corrected_free, out_frequency
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   o_m_tlast;
    // out_dropped
    logic                   o_m_tuser;

    int tx_idle_pct  = 17;
    int rx_idle_pct  = 62;
    int records_sent = 0;
    int failures;
    int pending;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    record_sort_by_free_energy dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    rsfe_sort_checker u_sort_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_m_tdata  (o_m_tdata),
        .i_m_tlast  (o_m_tlast),
        .i_m_tuser  (o_m_tuser),
        .o_failures (failures),
        .o_pending  (pending)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_m_tready <= 1'b0;
        else
            i_m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // mix of rails, tiny values that make equal keys, and full-width noise
    function automatic logic [63:0] pick_energy();
        logic signed [2:0] tiny;
        tiny = 3'($urandom);
        case ($urandom_range(9))
            0:       return E_MAX;
            1:       return E_MIN;
            2, 3:    return 64'(tiny);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_record(input logic [7:0] id, input logic [63:0] opt,
                               input logic [63:0] free, input logic [63:0] point,
                               input logic [63:0] freq, input logic last_rec);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {freq, point, free, opt, id};
        i_s_tlast  <= last_rec;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        records_sent++;
    endtask

    task automatic send_set(input int n);
        for (int k = 0; k < n; k++)
            send_record(8'($urandom), pick_energy(), pick_energy(), pick_energy(),
                        pick_energy(), k == n - 1);
    endtask

    initial begin
        int           set_n;
        int           r;
        logic [63:0]  same;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single record, key clamps high
        send_record(8'h00, E_MIN, E_MAX, E_MAX, E_MAX, 1'b1);
        // two records in reverse order, second key clamps low
        send_record(8'hFF, '0, '0, '0, E_MIN, 1'b0);
        send_record(8'h01, E_MAX, E_MIN, E_MIN, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        // full store plus two dropped beats, the final one among them
        for (int k = 0; k < 18; k++) begin
            same = {$urandom, $urandom};
            case (k)
                0:       send_record(8'(100 + k), '0, '0, E_MAX, same, 1'b0);
                1:       send_record(8'(100 + k), 64'd1, 64'd1, E_MAX, same, 1'b0);
                2:       send_record(8'(100 + k), '1, '1, E_MIN, same, 1'b0);
                default: send_record(8'(100 + k), same, same, 64'(-(k / 2)),
                                     {$urandom, $urandom}, k == 17);
            endcase
        end

        while (records_sent < DIRECTED_N + RANDOM_N) begin
            r = records_sent - DIRECTED_N;
            if (r < RANDOM_N / 3) begin
                tx_idle_pct = 17;
                rx_idle_pct = 62;
            end else if (r < 2 * RANDOM_N / 3) begin
                tx_idle_pct = 62;
                rx_idle_pct = 17;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if ($urandom_range(9) == 0)
                set_n = $urandom_range(17, 20);
            else
                set_n = $urandom_range(1, MAX_RECORDS);
            send_set(set_n);
        end
        i_s_tvalid <= 1'b0;

        repeat (2) @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("simulation failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/rsfe_pkg.sv
rtl/rsfe_ram.sv
rtl/rsfe_key.sv
rtl/record_sort_by_free_energy.sv
tb/rsfe_sort_checker.sv
tb/tb_record_sort_by_free_energy.sv
